// ----- hw/rtl/seven_segment_text_encoder_top_assert.svh -----
`ifndef SEVEN_SEGMENT_TEXT_ENCODER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_TEXT_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define SSENC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SSENC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ssenc_pkg.sv -----
package ssenc_pkg;

	localparam logic [7:0] LED_CMD    = 8'd134;
	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] DOT_CHAR   = 8'h2e;
	localparam logic [7:0] UNDER_CHAR = 8'h5f;
	localparam logic [7:0] DASH_CHAR  = 8'h2d;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] NINE_CHAR  = 8'h39;

	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] SEG_DASH  = 8'h40;
	localparam logic [7:0] SEG_POINT = 8'h80;

	localparam logic [1:0] POS_LEFT = 2'd3;
	localparam logic [1:0] POS_NONE = 2'd0;

	typedef struct packed {
		logic       fire;
		logic [7:0] code;
	} step_t;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] middle;
		logic [7:0] right;
	} segs_t;

	function automatic logic [7:0] digit_segs(input logic [3:0] d);
		logic [7:0] s;
		unique case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ----- hw/rtl/ssenc_digits.sv -----
module ssenc_digits (
	input  logic             clk,
	input  logic             arst_n,
	input  ssenc_pkg::step_t step,
	output ssenc_pkg::segs_t segs,
	output logic [1:0]       next_pos
);
	import ssenc_pkg::*;

	logic [1:0]      next_pos_q, next_pos_d;
	logic [1:0]      last_pos_q, last_pos_d;
	logic            point_ok_q, point_ok_d;
	logic [2:0][7:0] seg_q, seg_d;
	logic            is_digit;
	logic            fills;
	logic [7:0]      code;

	always_comb begin
		is_digit = (step.code >= ZERO_CHAR) && (step.code <= NINE_CHAR);
		fills    = is_digit || (step.code == UNDER_CHAR) || (step.code == DASH_CHAR);
		priority if (is_digit) begin
			code = digit_segs(step.code[3:0]);
		end else if (step.code == DASH_CHAR) begin
			code = SEG_DASH;
		end else begin
			code = SEG_BLANK;
		end
	end

	always_comb begin
		next_pos_d = next_pos_q;
		last_pos_d = last_pos_q;
		point_ok_d = point_ok_q;
		seg_d      = seg_q;
		if (step.fire) begin
			priority if (step.code == NUL_CHAR) begin
				next_pos_d = POS_LEFT;
				last_pos_d = POS_NONE;
				point_ok_d = 1'b0;
				seg_d      = '0;
			end else if (step.code == DOT_CHAR && point_ok_q) begin
				if (last_pos_q != POS_NONE) begin
					seg_d[last_pos_q - 2'd1] = seg_q[last_pos_q - 2'd1] | SEG_POINT;
				end
				point_ok_d = 1'b0;
			end else begin
				point_ok_d = 1'b0;
				if (fills && next_pos_q != POS_NONE) begin
					seg_d[next_pos_q - 2'd1] = code;
					last_pos_d = next_pos_q;
					next_pos_d = next_pos_q - 2'd1;
					point_ok_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_pos_q <= POS_LEFT;
			last_pos_q <= POS_NONE;
			point_ok_q <= 1'b0;
			seg_q      <= '0;
		end else begin
			next_pos_q <= next_pos_d;
			last_pos_q <= last_pos_d;
			point_ok_q <= point_ok_d;
			seg_q      <= seg_d;
		end
	end

	assign segs.left   = seg_q[2];
	assign segs.middle = seg_q[1];
	assign segs.right  = seg_q[0];
	assign next_pos    = next_pos_q;

endmodule

// ----- hw/rtl/seven_segment_text_encoder_top.sv -----
// channel  | handshake               | payload
// char     | char_valid, char_stall  | char_code
// res      | res_valid, res_stall    | command_code, left/middle/right_segments
//
// one character accepted per cycle while not stalled; each passes an input
// register, then the digit update; an advancing NUL loads the result register
// reset empties both registers and sets the leftmost position as next to fill
// char_stall rises only when a NUL waits in the input register behind a
// result that is still stalled; other characters never wait
`include "seven_segment_text_encoder_top_assert.svh"

module seven_segment_text_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] command_code,
	output logic [7:0] left_segments,
	output logic [7:0] middle_segments,
	output logic [7:0] right_segments
);
	import ssenc_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       nul_s1;
	logic       adv_s1;
	logic       res_valid_q;
	segs_t      res_segs_q;
	segs_t      segs;
	step_t      step;
	logic [1:0] next_pos;

	assign nul_s1     = (char_s1 == NUL_CHAR);
	assign adv_s1     = valid_s1 && (!nul_s1 || !res_valid_q || !res_stall);
	assign char_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
		end
	end

	assign step.fire = adv_s1;
	assign step.code = char_s1;

	ssenc_digits u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.segs     (segs),
		.next_pos (next_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && nul_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && nul_s1) begin
			res_segs_q <= segs;
		end
	end

	assign res_valid       = res_valid_q;
	assign command_code    = LED_CMD;
	assign left_segments   = res_segs_q.left;
	assign middle_segments = res_segs_q.middle;
	assign right_segments  = res_segs_q.right;

	`SSENC_ASSERT_NEXT(a_nul_loads_result, adv_s1 && nul_s1, res_valid_q, "NUL did not load result")
	`SSENC_ASSERT_NEXT(a_nul_rewinds, adv_s1 && nul_s1, next_pos == POS_LEFT, "NUL did not rewind position")
	`SSENC_ASSERT_NOW(a_stall_cause, char_stall, valid_s1 && nul_s1 && res_valid_q && res_stall, "stall without waiting NUL")
	`SSENC_ASSERT_NOW(a_no_stall_empty, !valid_s1, !char_stall, "stall with empty input register")

endmodule
